// ----- sv/adpcm_speech_decoder_macros.svh -----
// Assertion macros shared by the checker file.
`ifndef ADPCM_SPEECH_DECODER_MACROS_SVH
`define ADPCM_SPEECH_DECODER_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define ADSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adsd assertion failed");

// Concurrent check that also holds during reset.
`define ADSD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("adsd reset assertion failed");

`endif

// ----- sv/adsd_pkg.sv -----
// ----------------------------------------------------------------------------
// adsd_pkg
// Types, constants and table functions of the ADPCM speech decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adsd_pkg;

    localparam int ZERO_TAPS_DEF = 6;
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_MODE = 1'b0,
        CFG_LSB_FIRST = 1'b1
    } t_cfg_idx;

    localparam logic signed [15:0] TONE_LIMIT = -16'sd11776;
    localparam logic [12:0]        FAST_MIN   = 13'd544;
    localparam logic [12:0]        FAST_MAX   = 13'd5120;
    localparam logic signed [17:0] POLE0_LIM  = 18'sd15360;
    localparam logic signed [17:0] POLE1_LIM  = 18'sd12288;
    localparam logic [18:0]        SLOW_RST   = 19'd34816;
    localparam logic [12:0]        MIX_LOW    = 13'd1535;
    localparam logic [9:0]         AP_TRANS   = 10'd256;
    localparam logic [14:0]        THR_CAP    = 15'h1f << 10;

    typedef struct packed {
        logic       sign;
        logic [4:0] exp;
        logic [5:0] mant;
    } t_fl;

    localparam t_fl FL_RESET = '{sign: 1'b0, exp: 5'd0, mant: 6'd32};

    typedef struct packed {
        logic       load;
        logic       quant;
        logic       adapt;
        logic       scale;
        logic       mix;
        logic       pred;
        logic       emit;
        logic       last;
        logic [1:0] code_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic wide;
        logic pred_last;
    } t_dp_status;

    // Fold the code onto its magnitude index (tables are mirror symmetric).
    function automatic logic [2:0] mag_idx(input logic [3:0] code, input logic wide);
        logic [2:0] m;
        if (wide) begin
            m = code[3] ? ~code[2:0] : code[2:0];
        end else begin
            m = {2'b00, code[1] ? ~code[0] : code[0]};
        end
        return m;
    endfunction

    // Log of the quantized difference; negative marks a zero difference.
    function automatic logic signed [10:0] dqln_lut(input logic [3:0] code, input logic wide);
        logic signed [10:0] v;
        logic [2:0]         m;
        m = mag_idx(code, wide);
        if (!wide) begin
            v = m[0] ? 11'sd365 : 11'sd116;
        end else begin
            case (m)
                3'd0: v = -11'sd1;
                3'd1: v = 11'sd4;
                3'd2: v = 11'sd135;
                3'd3: v = 11'sd213;
                3'd4: v = 11'sd273;
                3'd5: v = 11'sd323;
                3'd6: v = 11'sd373;
                3'd7: v = 11'sd425;
                default: v = -11'sd1;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [11:0] wmul_lut(input logic [3:0] code, input logic wide);
        logic signed [11:0] v;
        logic [2:0]         m;
        m = mag_idx(code, wide);
        if (!wide) begin
            v = m[0] ? 12'sd439 : -12'sd22;
        end else begin
            case (m)
                3'd0: v = -12'sd12;
                3'd1: v = 12'sd18;
                3'd2: v = 12'sd41;
                3'd3: v = 12'sd64;
                3'd4: v = 12'sd112;
                3'd5: v = 12'sd198;
                3'd6: v = 12'sd355;
                3'd7: v = 12'sd1122;
                default: v = -12'sd12;
            endcase
        end
        return v;
    endfunction

    function automatic logic [2:0] fval_lut(input logic [3:0] code, input logic wide);
        logic [2:0] v;
        logic [2:0] m;
        m = mag_idx(code, wide);
        if (!wide) begin
            v = m[0] ? 3'd7 : 3'd0;
        end else begin
            case (m)
                3'd3, 3'd4, 3'd5: v = 3'd1;
                3'd6:             v = 3'd3;
                3'd7:             v = 3'd7;
                default:          v = 3'd0;
            endcase
        end
        return v;
    endfunction

    // Sign, bit count and six leading bits; zero maps to mantissa 32.
    function automatic t_fl to_float(input logic signed [17:0] v);
        logic [17:0] m;
        logic [4:0]  e;
        logic [23:0] sh;
        t_fl         f;
        m = v[17] ? 18'(-v) : 18'(v);
        e = '0;
        for (int i = 0; i < 18; i++) begin
            if (m[i]) begin
                e = 5'(i + 1);
            end
        end
        sh     = {m, 6'b0} >> e;
        f.sign = v[17];
        f.exp  = e;
        f.mant = (m == '0) ? 6'd32 : sh[5:0];
        return f;
    endfunction

    function automatic logic signed [21:0] fmul(input t_fl a, input t_fl b);
        logic [5:0]  e;
        logic [11:0] p;
        logic [11:0] ps;
        logic [7:0]  r;
        logic [21:0] q;
        e  = 6'(a.exp) + 6'(b.exp);
        p  = a.mant * b.mant;
        ps = (p + 12'd48) >> 4;
        r  = ps[7:0];
        if (e > 6'd19) begin
            q = ((e - 6'd19) < 6'd20) ? (22'(r) << (e - 6'd19)) : '0;
        end else begin
            q = 22'(r) >> (6'd19 - e);
        end
        return (a.sign ^ b.sign) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ----- sv/adsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// adsd_ctrl
// Sequencer: accepts a byte, steps each code through the datapath, owns the
// output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  adsd_pkg::t_dp_status  i_status,
    output adsd_pkg::t_dp_cmd     o_cmd
);
    import adsd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_QUANT = 7'b0000010,
        S_ADAPT = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_MIX   = 7'b0010000,
        S_PRED  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_out_valid, n_out_valid;
    logic       last_code;
    logic       out_free;

    assign last_code = i_status.wide ? (r_k == 2'd1) : (r_k == 2'd3);
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_out_valid  = r_out_valid && i_stall;
        o_cmd        = '0;
        o_cmd.last   = last_code;
        o_cmd.code_idx = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_k        = 2'd0;
                    n_state    = S_QUANT;
                end
            end
            S_QUANT: begin
                o_cmd.quant = 1'b1;
                n_state     = S_ADAPT;
            end
            S_ADAPT: begin
                o_cmd.adapt = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_PRED;
            end
            S_PRED: begin
                o_cmd.pred = 1'b1;
                if (i_status.pred_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (last_code) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_QUANT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- sv/adsd_dp.sv -----
// ----------------------------------------------------------------------------
// adsd_dp
// Datapath: unpacking, inverse quantizer, scale and speed adaptation,
// predictor update and the shared eight-tap predictor multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsd_dp #(
    parameter int ZERO_TAPS = adsd_pkg::ZERO_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [0:0]                        i_cfg_data,
    input  logic [7:0]                        i_code_byte,
    input  adsd_pkg::t_dp_cmd                 i_cmd,
    output adsd_pkg::t_dp_status              o_status,
    output logic signed [15:0]                o_pcm_sample,
    output logic                              o_last_of_byte
);
    import adsd_pkg::*;

    localparam int NTAPS = ZERO_TAPS + 2;
    localparam int TW    = $clog2(NTAPS);

    // configuration and the byte under work
    logic       r_rate_mode, r_lsb_first;
    logic [7:0] r_byte;
    logic       r_wide, r_lsb;

    // decoder state
    logic signed [15:0] r_a [2];
    logic signed [16:0] r_b [ZERO_TAPS];
    logic [1:0]         r_psh_neg;
    t_fl                r_sr_hist [2];
    t_fl                r_dq_hist [ZERO_TAPS];
    logic [12:0]        r_fast;
    logic [18:0]        r_slow;
    logic [12:0]        r_mixed;
    logic [11:0]        r_short;
    logic [13:0]        r_long;
    logic [9:0]         r_ap;
    logic               r_tone;
    logic signed [20:0] r_se, r_pe;

    // per-code values
    logic signed [16:0] r_dq;
    logic               r_isig, r_tr;
    logic signed [15:0] r_sr;
    logic               r_pk0_zero, r_pk0_neg, r_dq0_zero;

    // predictor loop
    logic [TW-1:0]      r_tap;
    logic signed [21:0] r_acc;

    // output register
    logic signed [15:0] r_pcm;
    logic               r_last;

    // ---------------- unpack ----------------
    logic [2:0] shamt;
    logic [7:0] shifted;
    logic [3:0] code;
    logic       isig;

    always_comb begin
        if (r_wide) begin
            shamt = r_lsb ? {i_cmd.code_idx[0], 2'b00} : {~i_cmd.code_idx[0], 2'b00};
        end else begin
            shamt = r_lsb ? {i_cmd.code_idx, 1'b0} : 3'd6 - {i_cmd.code_idx, 1'b0};
        end
        shifted = r_byte >> shamt;
        code    = r_wide ? shifted[3:0] : {2'b00, shifted[1:0]};
        isig    = r_wide ? code[3] : code[1];
    end

    // ---------------- inverse quantizer ----------------
    logic signed [10:0] dqln;
    logic [11:0]        dql;
    logic [22:0]        dsh;
    logic [15:0]        mag;
    logic [3:0]         ylint;
    logic [14:0]        thr2;
    logic [16:0]        thr3;
    logic               tr;
    logic signed [16:0] dq;
    logic signed [21:0] sr_sum, pk_sum;

    always_comb begin
        dqln  = dqln_lut(code, r_wide);
        dql   = {3'b000, dqln[8:0]} + {1'b0, r_mixed[12:2]};
        dsh   = 23'({1'b1, dql[6:0]}) << dql[10:7];
        mag   = dqln[10] ? 16'd0 : dsh[22:7];
        ylint = r_slow[18:15];
        thr2  = (ylint > 4'd9) ? THR_CAP : (15'({1'b1, r_slow[14:10]}) << ylint);
        thr3  = {2'b00, thr2} + {1'b0, thr2, 1'b0};
        tr    = r_tone && ({1'b0, mag} > thr3[16:2]);
        dq    = isig ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        sr_sum = 22'(r_se) + 22'(dq);
        pk_sum = 22'(r_pe) + 22'(dq);
    end

    // ---------------- predictor and scale adaptation ----------------
    logic signed [16:0] t_pole, fa1_raw, fa1;
    logic signed [8:0]  u1, u0;
    logic signed [17:0] a1_sum, a1c, a0_sum, a0c, lim;
    logic signed [17:0] b_sum [ZERO_TAPS];
    logic signed [8:0]  ub [ZERO_TAPS];
    logic [2:0]         fi;
    logic signed [11:0] wi;
    logic signed [13:0] s_short, ns_short;
    logic signed [15:0] s_long, ns_long;
    logic signed [14:0] s_mix, f_sum, f_clamp;
    t_fl                dq_fl;

    always_comb begin
        t_pole = r_pk0_zero ? 17'sd0 :
                 ((r_psh_neg[0] == r_pk0_neg) ? -17'(r_a[0]) : 17'(r_a[0]));
        fa1_raw = t_pole >>> 5;
        if (fa1_raw > 17'sd255) begin
            fa1 = 17'sd255;
        end else if (fa1_raw < -17'sd256) begin
            fa1 = -17'sd256;
        end else begin
            fa1 = fa1_raw;
        end
        u1 = r_pk0_zero ? 9'sd0 : ((r_psh_neg[1] ^ r_pk0_neg) ? -9'sd128 : 9'sd128);
        u0 = r_pk0_zero ? 9'sd0 : ((r_psh_neg[0] ^ r_pk0_neg) ? -9'sd192 : 9'sd192);
        a1_sum = 18'(r_a[1]) + 18'(u1) + 18'(fa1) - 18'(r_a[1] >>> 7);
        if (a1_sum > POLE1_LIM) begin
            a1c = POLE1_LIM;
        end else if (a1_sum < -POLE1_LIM) begin
            a1c = -POLE1_LIM;
        end else begin
            a1c = a1_sum;
        end
        lim    = POLE0_LIM - a1c;
        a0_sum = 18'(r_a[0]) + 18'(u0) - 18'(r_a[0] >>> 8);
        if (a0_sum > lim) begin
            a0c = lim;
        end else if (a0_sum < -lim) begin
            a0c = -lim;
        end else begin
            a0c = a0_sum;
        end
        for (int i = 0; i < ZERO_TAPS; i++) begin
            ub[i] = r_dq0_zero ? 9'sd0 :
                    ((r_isig ^ r_dq_hist[i].sign) ? -9'sd128 : 9'sd128);
            b_sum[i] = 18'(r_b[i]) + 18'(ub[i]) - 18'(r_b[i] >>> 8);
        end

        // the code's sign bit stands even for a zero difference
        dq_fl      = to_float(18'(r_dq));
        dq_fl.sign = r_isig;

        fi       = fval_lut(code, r_wide);
        wi       = wmul_lut(code, r_wide);
        s_short  = $signed({2'b00, r_short});
        ns_short = s_short + $signed({7'b0, fi, 4'b0}) + ((-s_short) >>> 5);
        s_long   = $signed({2'b00, r_long});
        ns_long  = s_long + $signed({9'b0, fi, 4'b0}) + ((-s_long) >>> 7);
        s_mix    = $signed({2'b00, r_mixed});
        f_sum    = s_mix + 15'(wi) + ((-s_mix) >>> 5);
        if (f_sum < $signed({2'b00, FAST_MIN})) begin
            f_clamp = $signed({2'b00, FAST_MIN});
        end else if (f_sum > $signed({2'b00, FAST_MAX})) begin
            f_clamp = $signed({2'b00, FAST_MAX});
        end else begin
            f_clamp = f_sum;
        end
    end

    // ---------------- speed control and slow scale ----------------
    logic               tone_n;
    logic signed [15:0] d_diff, d_abs;
    logic signed [10:0] s_ap, ap1, ap2;
    logic               ap_inc;
    logic signed [20:0] s_slow, ns_slow;

    always_comb begin
        tone_n = r_a[1] < TONE_LIMIT;
        d_diff = $signed({2'b00, r_short, 2'b00}) - $signed({2'b00, r_long});
        d_abs  = d_diff[15] ? -d_diff : d_diff;
        ap_inc = (r_mixed <= MIX_LOW) || tone_n ||
                 (d_abs >= $signed({5'b0, r_long[13:3]}));
        s_ap   = $signed({1'b0, r_ap});
        ap1    = s_ap + ((-s_ap) >>> 4);
        ap2    = ap1 + (ap_inc ? 11'sd32 : 11'sd0);
        s_slow  = $signed({2'b00, r_slow});
        ns_slow = s_slow + $signed({8'b0, r_fast}) + ((-s_slow) >>> 6);
    end

    // ---------------- mixed scale ----------------
    logic [6:0]         sl;
    logic signed [13:0] fs_diff;
    logic signed [21:0] mprod;
    logic signed [22:0] msum, mshift;

    always_comb begin
        sl      = (r_ap >= AP_TRANS) ? 7'd64 : r_ap[8:2];
        fs_diff = $signed({1'b0, r_fast}) - $signed({1'b0, r_slow[18:6]});
        mprod   = fs_diff * $signed({1'b0, sl});
        msum    = $signed({4'b0, r_slow}) + 23'(mprod);
        mshift  = msum >>> 6;
    end

    // ---------------- shared predictor tap ----------------
    logic signed [17:0] c_all [NTAPS];
    t_fl                h_all [NTAPS];
    logic signed [21:0] tap_prod, acc_n, acc_half;

    always_comb begin
        for (int i = 0; i < ZERO_TAPS; i++) begin
            c_all[i] = 18'(r_b[i] >>> 2);
            h_all[i] = r_dq_hist[i];
        end
        for (int j = 0; j < 2; j++) begin
            c_all[ZERO_TAPS + j] = 18'(r_a[j] >>> 2);
            h_all[ZERO_TAPS + j] = r_sr_hist[j];
        end
        tap_prod = fmul(to_float(c_all[r_tap]), h_all[r_tap]);
        acc_n    = r_acc + tap_prod;
        acc_half = acc_n >>> 1;
    end

    assign o_status.wide      = r_wide;
    assign o_status.pred_last = (r_tap == TW'(NTAPS - 1));

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_code_byte;
            r_wide <= r_rate_mode;
            r_lsb  <= r_lsb_first;
        end
        if (i_cmd.quant) begin
            r_dq       <= dq;
            r_isig     <= isig;
            r_tr       <= tr;
            r_sr       <= sr_sum[15:0];
            r_pk0_zero <= (pk_sum == 22'sd0);
            r_pk0_neg  <= pk_sum[21];
            r_dq0_zero <= (mag == 16'd0);
        end
        if (i_cmd.mix) begin
            r_tap <= '0;
            r_acc <= '0;
        end else if (i_cmd.pred) begin
            r_tap <= r_tap + 1'b1;
            r_acc <= acc_n;
        end
        if (i_cmd.emit) begin
            // saturate the reconstructed signal times four
            if (r_sr > 16'sd8191) begin
                r_pcm <= 16'sd32767;
            end else if (r_sr < -16'sd8192) begin
                r_pcm <= -16'sd32768;
            end else begin
                r_pcm <= $signed({r_sr[13:0], 2'b00});
            end
            r_last <= i_cmd.last;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode <= 1'b0;
            r_lsb_first <= 1'b0;
            r_a[0]      <= '0;
            r_a[1]      <= '0;
            for (int i = 0; i < ZERO_TAPS; i++) begin
                r_b[i]       <= '0;
                r_dq_hist[i] <= FL_RESET;
            end
            r_psh_neg    <= 2'b00;
            r_sr_hist[0] <= FL_RESET;
            r_sr_hist[1] <= FL_RESET;
            r_fast       <= FAST_MIN;
            r_slow       <= SLOW_RST;
            r_mixed      <= FAST_MIN;
            r_short      <= '0;
            r_long       <= '0;
            r_ap         <= '0;
            r_tone       <= 1'b0;
            r_se         <= '0;
            r_pe         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE_MODE: r_rate_mode <= i_cfg_data[0];
                    CFG_LSB_FIRST: r_lsb_first <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.adapt) begin
                // a transition clears every predictor coefficient
                r_a[1] <= r_tr ? 16'sd0 : a1c[15:0];
                r_a[0] <= r_tr ? 16'sd0 : a0c[15:0];
                for (int i = 0; i < ZERO_TAPS; i++) begin
                    r_b[i] <= r_tr ? 17'sd0 : b_sum[i][16:0];
                end
                r_psh_neg    <= {r_psh_neg[0], !r_pk0_zero && r_pk0_neg};
                r_sr_hist[1] <= r_sr_hist[0];
                r_sr_hist[0] <= to_float(18'(r_sr));
                for (int i = ZERO_TAPS - 1; i > 0; i--) begin
                    r_dq_hist[i] <= r_dq_hist[i - 1];
                end
                r_dq_hist[0] <= dq_fl;
                r_short <= ns_short[11:0];
                r_long  <= ns_long[13:0];
                r_fast  <= f_clamp[12:0];
            end
            if (i_cmd.scale) begin
                r_tone <= tone_n;
                r_ap   <= r_tr ? AP_TRANS : ap2[9:0];
                r_slow <= ns_slow[18:0];
            end
            if (i_cmd.mix) begin
                r_mixed <= mshift[12:0];
            end
            if (i_cmd.pred) begin
                if (r_tap == TW'(ZERO_TAPS - 1)) begin
                    r_pe <= acc_half[20:0];
                end
                if (r_tap == TW'(NTAPS - 1)) begin
                    r_se <= acc_half[20:0];
                end
            end
        end
    end

    assign o_pcm_sample   = r_pcm;
    assign o_last_of_byte = r_last;

endmodule

// ----- sv/adpcm_speech_decoder.sv -----
// ----------------------------------------------------------------------------
// adpcm_speech_decoder
// G.726 ADPCM decoder at 16 or 32 kbit/s with byte unpacking.
// ----------------------------------------------------------------------------
// Each code runs four update steps and eight passes through the one shared
// predictor tap multiplier, then the output register load, which waits while
// the held sample is stalled. A byte holds two codes at 32 kbit/s and four
// at 16 kbit/s; o_stall stays high until the last code's sample is loaded.
// Synchronous active-low reset restores the scheme's initial decoder state.
`timescale 1ns / 1ps

module adpcm_speech_decoder #(
    parameter int ZERO_TAPS = adsd_pkg::ZERO_TAPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [adsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [0:0]                     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_code_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [15:0]             o_pcm_sample,
    output logic                           o_last_of_byte
);
    import adsd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    adsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    adsd_dp #(
        .ZERO_TAPS (ZERO_TAPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_code_byte    (i_code_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_pcm_sample   (o_pcm_sample),
        .o_last_of_byte (o_last_of_byte)
    );

endmodule

// ----- sv/adsd_checker.sv -----
// ----------------------------------------------------------------------------
// adsd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adpcm_speech_decoder_macros.svh"

module adsd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_pcm_sample,
    input logic               o_last_of_byte
);

    // a stalled sample holds
    `ADSD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_pcm_sample) && $stable(o_last_of_byte)))
    // a byte transfer starts work on its codes
    `ADSD_ASSERT(a_busy_after_in, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    // more codes of the byte remain while a non-final sample transfers
    `ADSD_ASSERT(a_busy_mid_byte, i_clk, i_rst_n, (o_valid && !i_stall && !o_last_of_byte) |-> o_stall)
    // reset drops the output valid
    `ADSD_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind adpcm_speech_decoder adsd_checker u_adsd_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the ADPCM speech decoder against a bit-exact G.726 decoder model kept
// in a scoreboard class, over directed bytes and random streams at both rates
// and both unpacking orders, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import adsd_pkg::*;

    typedef struct {
        int sign;
        int unsigned ex;
        int unsigned mant;
    } fl_rec;

    typedef struct {
        logic signed [15:0] pcm;
        logic               last;
    } pcm_rec;

    class pcm_scoreboard;
        int          errors;
        bit          wide_mode;
        bit          low_first;
        pcm_rec      pending_pcm[$];
        int          a_pole[2];
        int          b_zero[6];
        int          pk_hist[2];
        fl_rec       sr_fl[2];
        fl_rec       dq_fl[6];
        int          yu, yl, y, dms, dml, ap, al, td, sez_est, se_est;
        int          dqln4[16] = '{-1, 4, 135, 213, 273, 323, 373, 425,
                                   425, 373, 323, 273, 213, 135, 4, -1};
        int          wm4[16]   = '{-12, 18, 41, 64, 112, 198, 355, 1122,
                                   1122, 355, 198, 112, 64, 41, 18, -12};
        int          fv4[16]   = '{0, 0, 0, 1, 1, 1, 3, 7, 7, 3, 1, 1, 1, 0, 0, 0};
        int          dqln2[4]  = '{116, 365, 365, 116};
        int          wm2[4]    = '{-22, 439, 439, -22};
        int          fv2[4]    = '{0, 7, 7, 0};

        function new();
            fl_rec z;
            z.sign = 0;
            z.ex   = 0;
            z.mant = 32;
            errors = 0;
            wide_mode = 0;
            low_first = 0;
            foreach (a_pole[i]) begin
                a_pole[i] = 0;
                pk_hist[i] = 1;
                sr_fl[i] = z;
            end
            foreach (b_zero[i]) begin
                b_zero[i] = 0;
                dq_fl[i] = z;
            end
            yu = 544;
            yl = 34816;
            y = 544;
            dms = 0;
            dml = 0;
            ap = 0;
            al = 0;
            td = 0;
            sez_est = 0;
            se_est = 0;
        endfunction

        function int clip(int x, int lo, int hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function fl_rec to_fl(int v);
            fl_rec       f;
            int unsigned m;
            int unsigned e;
            longint unsigned sh;
            m = v < 0 ? 32'(-v) : 32'(v);
            e = 0;
            while (e < 32 && (m >> e) != 0) e++;
            sh = (longint'(m) << 6) >> e;
            f.sign = v < 0;
            f.ex = e;
            f.mant = m != 0 ? 32'(sh) : 32;
            return f;
        endfunction

        function int fl_mul(fl_rec a, fl_rec b);
            int unsigned e;
            int unsigned r;
            e = a.ex + b.ex;
            r = ((a.mant & 63) * (b.mant & 63) + 48) >> 4;
            if (e > 19) r = (e - 19 < 20) ? r << (e - 19) : 0;
            else r = r >> (19 - e);
            return (a.sign ^ b.sign) ? -int'(r) : int'(r);
        endfunction

        function int decode(int code);
            int          dqln, wi, fi, isig, dq, dql, sr, pk0, dq0, tr;
            int          ylint, ylfrac, thr2, fa1, a1, a0, d, se;
            int unsigned dex, dqt;
            logic [15:0] wrapped;
            dqln = wide_mode ? dqln4[code] : dqln2[code];
            wi   = wide_mode ? wm4[code] : wm2[code];
            fi   = wide_mode ? fv4[code] : fv2[code];
            isig = wide_mode ? (code >> 3) & 1 : (code >> 1) & 1;
            dq = 0;
            if (dqln >= 0) begin
                dql = dqln + (y >>> 2);
                if (dql >= 0) begin
                    dex = (dql >> 7) & 15;
                    dqt = 128 + (dql & 127);
                    dq = int'((dqt << dex) >> 7);
                end
            end
            ylint = yl >>> 15;
            ylfrac = (yl >>> 10) & 31;
            thr2 = ylint > 9 ? (31 << 10) : ((32 + ylfrac) << (ylint < 0 ? 0 : ylint));
            tr = (td == 1 && dq > ((3 * thr2) >>> 2)) ? 1 : 0;
            if (isig != 0) dq = -dq;
            wrapped = 16'(se_est + dq);
            sr = int'($signed(wrapped));
            pk0 = (sez_est + dq) == 0 ? 0 : ((sez_est + dq) < 0 ? -1 : 1);
            dq0 = dq == 0 ? 0 : (dq < 0 ? -1 : 1);
            if (tr != 0) begin
                a_pole[0] = 0;
                a_pole[1] = 0;
                foreach (b_zero[i]) b_zero[i] = 0;
            end else begin
                fa1 = clip((-a_pole[0] * pk_hist[0] * pk0) >>> 5, -256, 255);
                a1 = a_pole[1] + 128 * pk0 * pk_hist[1] + fa1 - (a_pole[1] >>> 7);
                a1 = clip(a1, -12288, 12288);
                a0 = a_pole[0] + 192 * pk0 * pk_hist[0] - (a_pole[0] >>> 8);
                a_pole[1] = a1;
                a_pole[0] = clip(a0, -(15360 - a1), 15360 - a1);
                foreach (b_zero[i])
                    b_zero[i] += 128 * dq0 * (dq_fl[i].sign != 0 ? -1 : 1) - (b_zero[i] >>> 8);
            end
            pk_hist[1] = pk_hist[0];
            pk_hist[0] = pk0 != 0 ? pk0 : 1;
            sr_fl[1] = sr_fl[0];
            sr_fl[0] = to_fl(sr);
            for (int i = 5; i > 0; i--) dq_fl[i] = dq_fl[i - 1];
            dq_fl[0] = to_fl(dq);
            dq_fl[0].sign = isig;
            td = a_pole[1] < -11776 ? 1 : 0;
            dms += (fi << 4) + ((-dms) >>> 5);
            dml += (fi << 4) + ((-dml) >>> 7);
            if (tr != 0) begin
                ap = 256;
            end else begin
                d = 4 * dms - dml;
                if (d < 0) d = -d;
                ap += (-ap) >>> 4;
                if (y <= 1535 || td == 1 || d >= (dml >>> 3)) ap += 32;
            end
            al = ap >= 256 ? 64 : (ap >>> 2);
            yu = clip(y + wi + ((-y) >>> 5), 544, 5120);
            yl += yu + ((-yl) >>> 6);
            y = (yl + (yu - (yl >>> 6)) * al) >>> 6;
            se = 0;
            foreach (b_zero[i]) se += fl_mul(to_fl(b_zero[i] >>> 2), dq_fl[i]);
            sez_est = se >>> 1;
            foreach (a_pole[i]) se += fl_mul(to_fl(a_pole[i] >>> 2), sr_fl[i]);
            se_est = se >>> 1;
            return clip(sr * 4, -32768, 32767);
        endfunction

        function void note_byte(logic [7:0] b);
            int     w, n, sh;
            pcm_rec r;
            w = wide_mode ? 4 : 2;
            n = 8 / w;
            for (int k = 0; k < n; k++) begin
                sh = low_first ? k * w : 8 - (k + 1) * w;
                r.pcm = 16'(decode((b >> sh) & ((1 << w) - 1)));
                r.last = (k == n - 1);
                pending_pcm.push_back(r);
            end
        endfunction

        function void check_sample(logic signed [15:0] pcm, logic last);
            pcm_rec r;
            if (pending_pcm.size() == 0) begin
                $error("unexpected sample pcm_sample=%0d", pcm);
                errors++;
                return;
            end
            r = pending_pcm.pop_front();
            if (pcm !== r.pcm) begin
                $error("pcm_sample expected %0d actual %0d", r.pcm, pcm);
                errors++;
            end
            if (last !== r.last) begin
                $error("last_of_byte expected %0d actual %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [0:0]         i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_code_byte;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_pcm_sample;
    logic               o_last_of_byte;

    pcm_scoreboard sb;
    bit            gaps_on;

    // directed bytes: all code values at 16 kbit/s, then both zero codes and
    // the largest magnitudes at 32 kbit/s
    logic [7:0] bytes_16k [6]  = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h1B, 8'hE4};
    logic [7:0] bytes_32k [11] = '{8'h0F, 8'hF0, 8'h00, 8'hFF, 8'h87, 8'h78,
                                   8'h77, 8'h77, 8'h77, 8'h88, 8'h88};

    adpcm_speech_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_byte    (i_code_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pcm_sample   (o_pcm_sample),
        .o_last_of_byte (o_last_of_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("adpcm_speech_decoder: mismatch");
        $finish;
    end

    // Sample result transfers and pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_sample(o_pcm_sample, o_last_of_byte);
        end
        i_stall <= gaps_on && ($urandom_range(99) < 22);
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_code_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b);
    endtask

    // Hold the sender until every sample has arrived, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pcm.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input bit val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_RATE_MODE) sb.wide_mode = val;
        else sb.low_first = val;
    endtask

    task automatic random_run(input int count);
        logic [7:0] b;
        int         n;
        n = 0;
        while (n < count) begin
            // Runs of one byte drive the signal into saturation and tones.
            if ($urandom_range(99) < 25) b = n[0] ? 8'h77 : 8'h88;
            else b = 8'($urandom_range(0, 255));
            repeat ($urandom_range(0, 3) == 0 ? 3 : 1) begin
                if (n < count) begin
                    send_byte(b);
                    n++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RATE_MODE;
        i_cfg_data = 1'b0;
        i_valid = 1'b0;
        i_code_byte = 8'h00;
        i_stall = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // 16 kbit/s, high bits first
        write_cfg(CFG_RATE_MODE, 1'b0);
        write_cfg(CFG_LSB_FIRST, 1'b0);
        foreach (bytes_16k[i])
            send_byte(bytes_16k[i]);
        drain();
        // 32 kbit/s including both zero codes and the largest magnitudes
        write_cfg(CFG_RATE_MODE, 1'b1);
        foreach (bytes_32k[i])
            send_byte(bytes_32k[i]);
        drain();
        write_cfg(CFG_LSB_FIRST, 1'b1);
        send_byte(8'h12);
        send_byte(8'h34);
        drain();
        write_cfg(CFG_RATE_MODE, 1'b0);
        send_byte(8'hE4);
        send_byte(8'h1B);
        drain();

        random_run(25);
        drain();
        write_cfg(CFG_RATE_MODE, 1'b1);
        gaps_on = 1'b0;
        random_run(30);
        drain();
        gaps_on = 1'b1;
        write_cfg(CFG_LSB_FIRST, 1'b0);
        random_run(30);
        drain();
        write_cfg(CFG_RATE_MODE, 1'b0);
        random_run(25);
        drain();

        while (sb.pending_pcm.size() != 0) begin
            $error("sample never arrived: pcm_sample expected %0d",
                   sb.pending_pcm[0].pcm);
            void'(sb.pending_pcm.pop_front());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("adpcm_speech_decoder: match");
        end else begin
            $display("adpcm_speech_decoder: mismatch");
        end
        $finish;
    end

endmodule
